// File: hdl/cnsr_pkg.sv
`timescale 1ns / 1ps
// cnsr_pkg: shared types and constants of the CAN node service responder.
// No dependencies; imported by every module of the block.
package cnsr_pkg;

   localparam int unsigned ID_W   = 29;
   localparam int unsigned LEN_W  = 4;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned NODE_W = 7;
   localparam int unsigned TID_W  = 5;
   localparam int unsigned TICK_W = 10;
   localparam int unsigned UP_W   = 32;
   localparam int unsigned TYPE_W = 16;
   localparam int unsigned NAME_W = 56;
   localparam int unsigned SVC_W  = 10;

   localparam logic [7:0]        TAIL_BASE        = 8'hC0;
   localparam logic [TICK_W-1:0] TICKS_PER_SECOND = 10'd1000;
   localparam logic [SVC_W-1:0]  INFO_SERVICE     = 10'd1;
   localparam logic [ID_W-1:0]   SERVICE_FLAG     = 29'h0000080;
   localparam logic [ID_W-1:0]   REQUEST_FLAG     = 29'h0008000;
   localparam logic [ID_W-1:0]   INFO_SERVICE_ID  = 29'h0010000;
   localparam logic [LEN_W-1:0]  FULL_LEN         = 4'd8;
   localparam logic [LEN_W-1:0]  ONE_BYTE_LEN     = 4'd1;

   localparam logic [NODE_W-1:0] OWN_NODE_RESET    = 7'd19;
   localparam logic [TYPE_W-1:0] STATUS_TYPE_RESET = 16'd341;
   localparam logic [NAME_W-1:0] DEVICE_NAME_RESET = 56'd32216116658531430;

   typedef enum logic [1:0] {
      CMD_FRAME   = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_REQUEST = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_OWN_NODE    = 2'd0,
      CSR_STATUS_TYPE = 2'd1,
      CSR_DEVICE_NAME = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_REPLY   = 2'd0,
      OP_STATUS  = 2'd1,
      OP_REQUEST = 2'd2,
      OP_PASS    = 2'd3
   } op_type;

   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_HOST = 1'b1;

   // one queued job between front and back
   typedef struct packed {
      op_type              op;
      logic [NODE_W-1:0]   node;     // requester or target
      logic [TID_W-1:0]    tid;
      logic [ID_W-1:0]     id;       // passed frame id
      logic [LEN_W-1:0]    len;
      logic [DATA_W-1:0]   data;     // passed payload, or uptime in low bits
      logic [NODE_W-1:0]   remote;
   } job_type;

endpackage

// File: hdl/cnsr_front.sv
`timescale 1ns / 1ps
// cnsr_front: accepts transactions, decodes frames, keeps tick/uptime/transfer ID
// and remote node state, and pushes jobs to the queue. Depends on cnsr_pkg.
module cnsr_front import cnsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_frame_id,
   input  logic [LEN_W-1:0]  req_frame_len,
   input  logic [DATA_W-1:0] req_frame_data,
   input  logic [NODE_W-1:0] req_target_node,
   input  logic              q_full,
   input  logic [NODE_W-1:0] own_node,
   input  logic [TYPE_W-1:0] status_type,
   output logic              push,
   output job_type           push_job
);

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [UP_W-1:0]   uptime_ff, uptime_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [NODE_W-1:0] detected_ff, detected_in;

   logic              accept;
   logic              tid_adv;
   logic [TICK_W-1:0] tick_next;
   logic [2:0]        byte_idx;
   logic [DATA_W-1:0] shifted;
   logic [TID_W-1:0]  rx_tid;
   logic              is_reply;
   cmd_type           cmd;

   assign accept   = req_valid && !q_full;
   assign cmd      = cmd_type'(req_cmd);
   assign tick_next = tick_ff + 10'd1;
   assign byte_idx = req_frame_len[3] ? 3'd7 : 3'(req_frame_len[2:0] - 3'd1);
   assign shifted  = req_frame_data >> {byte_idx, 3'b000};
   assign rx_tid   = (req_frame_len == '0) ? '0 : shifted[TID_W-1:0];
   assign is_reply = req_frame_id[7] && (req_frame_id[25:16] == INFO_SERVICE)
                     && req_frame_id[15] && (req_frame_id[14:8] == own_node);

   always_comb begin
      tick_in     = tick_ff;
      uptime_in   = uptime_ff;
      tid_in      = tid_ff;
      detected_in = detected_ff;
      push        = 1'b0;
      tid_adv     = 1'b0;
      push_job.op     = OP_PASS;
      push_job.node   = req_target_node;
      push_job.tid    = tid_ff;
      push_job.id     = req_frame_id;
      push_job.len    = req_frame_len;
      push_job.data   = req_frame_data;
      push_job.remote = detected_ff;
      unique case (cmd)
         CMD_FRAME: begin
            if (req_frame_id[7]) begin
               push_job.op   = OP_REPLY;
               push_job.node = req_frame_id[6:0];
               push_job.tid  = rx_tid;
               push          = accept && is_reply;
            end else if (req_frame_id[23:8] == status_type) begin
               if (accept && (req_frame_id[6:0] != own_node)) begin
                  detected_in = req_frame_id[6:0];
               end
            end else begin
               push = accept;
            end
         end
         CMD_TICK: begin
            push_job.op = OP_STATUS;
            if (accept) begin
               if (tick_next >= TICKS_PER_SECOND) begin
                  tick_in   = '0;
                  uptime_in = uptime_ff + 32'd1;
                  push      = 1'b1;
                  tid_adv   = 1'b1;
               end else begin
                  tick_in = tick_next;
               end
            end
            push_job.data = {32'd0, uptime_in};
         end
         CMD_REQUEST: begin
            push_job.op = OP_REQUEST;
            push        = accept;
            tid_adv     = accept;
         end
         CMD_NONE: begin
         end
         default: begin
         end
      endcase
      if (tid_adv) begin
         tid_in = tid_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         uptime_ff   <= '0;
         tid_ff      <= '0;
         detected_ff <= '0;
      end else begin
         tick_ff     <= tick_in;
         uptime_ff   <= uptime_in;
         tid_ff      <= tid_in;
         detected_ff <= detected_in;
      end
   end

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < TICKS_PER_SECOND)
      else $error("tick count out of range");

   a_tid_step: assert property (@(posedge clock) disable iff (reset)
      tid_adv |=> tid_ff == $past(tid_ff) + 5'd1)
      else $error("transfer ID did not advance");

   a_tid_hold: assert property (@(posedge clock) disable iff (reset)
      !tid_adv |=> $stable(tid_ff))
      else $error("transfer ID moved without a sent frame");

   a_uptime: assert property (@(posedge clock) disable iff (reset)
      !$stable(uptime_ff) |-> (tick_ff == '0))
      else $error("uptime changed away from a second boundary");

endmodule

// File: hdl/cnsr_queue.sv
`timescale 1ns / 1ps
// cnsr_queue: two-entry job queue between decode and frame build.
// Depends on cnsr_pkg.
module cnsr_queue import cnsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= 2'd2) && ((count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff)))
      else $error("queue pointers and count disagree");

endmodule

// File: hdl/cnsr_back.sv
`timescale 1ns / 1ps
// cnsr_back: builds result frames from queued jobs into the output register.
// Depends on cnsr_pkg.
module cnsr_back import cnsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  job_type           head,
   output logic              pop,
   input  logic [NODE_W-1:0] own_node,
   input  logic [TYPE_W-1:0] status_type,
   input  logic [NAME_W-1:0] device_name,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [ID_W-1:0]   rsp_out_id,
   output logic [LEN_W-1:0]  rsp_out_len,
   output logic [DATA_W-1:0] rsp_out_data,
   output logic [NODE_W-1:0] rsp_remote_node
);

   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [NODE_W-1:0] remote_ff, remote_in;
   logic [7:0]        tail;
   logic [ID_W-1:0]   own_id;

   assign pop    = q_not_empty && (!valid_ff || !rsp_stall);
   assign tail   = TAIL_BASE | {3'b000, head.tid};
   assign own_id = ID_W'(own_node);

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      kind_in   = KIND_TX;
      id_in     = head.id;
      len_in    = head.len;
      data_in   = head.data;
      remote_in = head.remote;
      if (pop) begin
         valid_in = 1'b1;
      end
      unique case (head.op)
         OP_REPLY: begin
            id_in   = INFO_SERVICE_ID | (ID_W'(head.node) << 8) | SERVICE_FLAG | own_id;
            len_in  = FULL_LEN;
            data_in = {tail, device_name};
         end
         OP_STATUS: begin
            id_in   = {5'd0, status_type, 1'b0, own_node};
            len_in  = FULL_LEN;
            data_in = {tail, 24'd0, head.data[UP_W-1:0]};
         end
         OP_REQUEST: begin
            id_in   = INFO_SERVICE_ID | REQUEST_FLAG | (ID_W'(head.node) << 8)
                      | SERVICE_FLAG | own_id;
            len_in  = ONE_BYTE_LEN;
            data_in = {56'd0, tail};
         end
         OP_PASS: begin
            kind_in = KIND_HOST;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         data_ff   <= data_in;
         remote_ff <= remote_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_id      = id_ff;
   assign rsp_out_len     = len_ff;
   assign rsp_out_data    = data_ff;
   assign rsp_remote_node = remote_ff;

endmodule

// File: hdl/can_node_service_responder_unit.sv
`timescale 1ns / 1ps
// can_node_service_responder_unit: top level, configuration registers and wiring.
// Depends on cnsr_pkg, cnsr_front, cnsr_queue and cnsr_back.
//
// Usage:
//   req_*  : one transaction per command: a received 29-bit frame, a millisecond
//            tick or a request to send an info request to req_target_node.
//   rsp_*  : zero or one result per command, in command order: a frame to
//            transmit (kind 0) or a received frame for the host (kind 1).
//   csr_*  : register writes (own node, status type, device name); always ready,
//            to be written only while the block is idle.
// A result passes through a queue entry and then the output register before
// it is valid on rsp_*.
// Throughput: one command per cycle while req_stall is low; decode feeds a
// two-entry queue, and frame build loads the output register from its head.
// Reset: counters, transfer ID and remote node clear; registers take their
// default values; queue and output empty.
// When rsp_stall is held the output register holds its transaction, the queue
// fills and then req_stall rises until the output drains.
module can_node_service_responder_unit import cnsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_frame_id,
   input  logic [LEN_W-1:0]  req_frame_len,
   input  logic [DATA_W-1:0] req_frame_data,
   input  logic [NODE_W-1:0] req_target_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [ID_W-1:0]   rsp_out_id,
   output logic [LEN_W-1:0]  rsp_out_len,
   output logic [DATA_W-1:0] rsp_out_data,
   output logic [NODE_W-1:0] rsp_remote_node,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [NAME_W-1:0] csr_data
);

   logic [NODE_W-1:0] own_node_ff, own_node_in;
   logic [TYPE_W-1:0] status_type_ff, status_type_in;
   logic [NAME_W-1:0] device_name_ff, device_name_in;

   logic    q_full, q_not_empty, push, pop;
   job_type push_job, head;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      own_node_in    = own_node_ff;
      status_type_in = status_type_ff;
      device_name_in = device_name_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWN_NODE:    own_node_in    = csr_data[NODE_W-1:0];
            CSR_STATUS_TYPE: status_type_in = csr_data[TYPE_W-1:0];
            CSR_DEVICE_NAME: device_name_in = csr_data;
            CSR_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff    <= OWN_NODE_RESET;
         status_type_ff <= STATUS_TYPE_RESET;
         device_name_ff <= DEVICE_NAME_RESET;
      end else begin
         own_node_ff    <= own_node_in;
         status_type_ff <= status_type_in;
         device_name_ff <= device_name_in;
      end
   end

   cnsr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_frame_id    (req_frame_id),
      .req_frame_len   (req_frame_len),
      .req_frame_data  (req_frame_data),
      .req_target_node (req_target_node),
      .q_full          (q_full),
      .own_node        (own_node_ff),
      .status_type     (status_type_ff),
      .push            (push),
      .push_job        (push_job)
   );

   cnsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   cnsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .head            (head),
      .pop             (pop),
      .own_node        (own_node_ff),
      .status_type     (status_type_ff),
      .device_name     (device_name_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_len     (rsp_out_len),
      .rsp_out_data    (rsp_out_data),
      .rsp_remote_node (rsp_remote_node)
   );

   a_pop_source: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("output loaded from an empty queue");

endmodule
